// ----- rtl/core/rpor_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Rotated point occupancy raster: shared package
// Field widths, status and register codes, and the structures passed between
// the transform pipeline, the occupancy map and the top level.
// ----------------------------------------------------------------------------
package rpor_pkg;

    localparam int MAX_SIDE_DEF  = 1024;
    localparam int DATA_W        = 32;
    localparam int SIDE_W        = 11;
    localparam int SIDE_MAX_CODE = 2047;
    localparam int IDX_W         = 22;   // holds y*side+x for any 11-bit side
    localparam int PIX_W         = 20;
    localparam int ST_W          = 2;
    localparam int WORD_W        = 32;
    localparam int BIT_W         = 5;
    localparam int FRAC_BITS     = 36;
    localparam int RFIFO_DEPTH   = 8;

    // Result status codes.
    localparam logic [ST_W-1:0] ST_PLOTTED   = 2'd0;
    localparam logic [ST_W-1:0] ST_CLIPPED   = 2'd1;
    localparam logic [ST_W-1:0] ST_DUPLICATE = 2'd2;

    // Configuration register indexes.
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_SIDE     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_R = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_I = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_X_REAL   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_X_IMAG   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_Y_REAL   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_Y_IMAG   = 3'd6;

    typedef struct packed {
        logic [SIDE_W-1:0] side;
        logic [DATA_W-1:0] center_real;
        logic [DATA_W-1:0] center_imag;
        logic [DATA_W-1:0] x_from_real;
        logic [DATA_W-1:0] x_from_imag;
        logic [DATA_W-1:0] y_from_real;
        logic [DATA_W-1:0] y_from_imag;
    } t_cfg;

    typedef struct packed {
        logic             valid;
        logic             clip;
        logic [IDX_W-1:0] idx;
    } t_map_req;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_index;
        logic [ST_W-1:0]  status;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_map_rsp;

endpackage
`default_nettype wire

// ----- rtl/core/rpor_xform.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Rotated point occupancy raster: coordinate pipeline
// Five stages: center offset, gain products, floored pixel coordinates,
// clip test, row-major index.
// ----------------------------------------------------------------------------
module rpor_xform #(
    parameter int MAX_SIDE = rpor_pkg::MAX_SIDE_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic [rpor_pkg::DATA_W-1:0]   i_point_real,
    input  wire logic [rpor_pkg::DATA_W-1:0]   i_point_imag,
    input  wire logic                          i_not_finite,
    input  wire rpor_pkg::t_cfg                i_cfg,
    output rpor_pkg::t_map_req                 o_req
);
    import rpor_pkg::*;

    localparam int SIDE_CAP = (MAX_SIDE < SIDE_MAX_CODE) ? MAX_SIDE : SIDE_MAX_CODE;
    localparam logic [SIDE_W-1:0] SIDE_CAP_V = SIDE_W'(SIDE_CAP);
    localparam int PROD_W = 2 * DATA_W + 1;   // 33 x 32 signed product
    localparam int SUM_W  = PROD_W + 1;
    localparam int CRD_W  = SUM_W - FRAC_BITS;

    logic [SIDE_W-1:0] side_eff;

    // Stage 0: offset from the viewport center.
    logic                r_s0_valid, r_s0_flag;
    logic signed [32:0]  r_dx, r_dy;
    // Stage 1: products.
    logic                r_s1_valid, r_s1_flag;
    logic signed [PROD_W-1:0] r_p_xr, r_p_xi, r_p_yr, r_p_yi;
    // Stage 2: floored coordinates.
    logic                r_s2_valid, r_s2_flag;
    logic [CRD_W-1:0]    r_px, r_py;
    // Stage 3: clip decision.
    logic                r_s3_valid, r_s3_clip;
    logic [SIDE_W-1:0]   r_px_s, r_py_s;
    // Stage 4: map request.
    logic                r_s4_valid, r_s4_clip;
    logic [IDX_W-1:0]    r_s4_idx;

    logic [SUM_W-1:0]    half_side, sum_x, sum_y;
    logic                px_out, py_out;
    logic [IDX_W-1:0]    n_idx;

    always_comb begin
        side_eff = (i_cfg.side > SIDE_CAP_V) ? SIDE_CAP_V : i_cfg.side;
    end

    // side/2 in the same fixed point as the products; odd sides give a half.
    always_comb begin
        half_side = {{(SUM_W - SIDE_W - FRAC_BITS + 1){1'b0}}, side_eff,
                     {(FRAC_BITS - 1){1'b0}}};
        sum_x = half_side + {r_p_xr[PROD_W-1], r_p_xr} - {r_p_xi[PROD_W-1], r_p_xi};
        sum_y = half_side - {r_p_yr[PROD_W-1], r_p_yr} - {r_p_yi[PROD_W-1], r_p_yi};
    end

    always_comb begin
        px_out = r_px[CRD_W-1]
               || (r_px[CRD_W-2:0] >= {{(CRD_W - 1 - SIDE_W){1'b0}}, side_eff});
        py_out = r_py[CRD_W-1]
               || (r_py[CRD_W-2:0] >= {{(CRD_W - 1 - SIDE_W){1'b0}}, side_eff});
        n_idx  = ({{(IDX_W - SIDE_W){1'b0}}, r_py_s} * {{(IDX_W - SIDE_W){1'b0}}, side_eff})
               + {{(IDX_W - SIDE_W){1'b0}}, r_px_s};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            r_s0_valid <= i_valid;
            r_s1_valid <= r_s0_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_flag <= i_not_finite;
        r_dx      <= $signed({i_point_real[DATA_W-1], i_point_real})
                   - $signed({i_cfg.center_real[DATA_W-1], i_cfg.center_real});
        r_dy      <= $signed({i_point_imag[DATA_W-1], i_point_imag})
                   - $signed({i_cfg.center_imag[DATA_W-1], i_cfg.center_imag});

        r_s1_flag <= r_s0_flag;
        r_p_xr    <= r_dx * $signed(i_cfg.x_from_real);
        r_p_xi    <= r_dy * $signed(i_cfg.x_from_imag);
        r_p_yr    <= r_dx * $signed(i_cfg.y_from_real);
        r_p_yi    <= r_dy * $signed(i_cfg.y_from_imag);

        // Taking the top bits of the sum is the floor division by 2^36.
        r_s2_flag <= r_s1_flag;
        r_px      <= sum_x[SUM_W-1:FRAC_BITS];
        r_py      <= sum_y[SUM_W-1:FRAC_BITS];

        r_s3_clip <= r_s2_flag || px_out || py_out;
        r_px_s    <= r_px[SIDE_W-1:0];
        r_py_s    <= r_py[SIDE_W-1:0];

        r_s4_clip <= r_s3_clip;
        r_s4_idx  <= n_idx;
    end

    assign o_req = '{valid: r_s4_valid, clip: r_s4_clip, idx: r_s4_idx};

endmodule
`default_nettype wire

// ----- rtl/core/rpor_map.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Rotated point occupancy raster: occupancy map
// One-bit-per-pixel map in a synchronous memory of 32-bit words. Each request
// reads its word, tests the pixel bit and, unless clipped or already set, writes
// the word back with the bit set. Each write is forwarded to the next request.
// ----------------------------------------------------------------------------
module rpor_map #(
    parameter int MAX_SIDE = rpor_pkg::MAX_SIDE_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire rpor_pkg::t_map_req i_req,
    output rpor_pkg::t_map_rsp      o_rsp,
    output logic                    o_clearing
);
    import rpor_pkg::*;

    localparam int MAP_WORDS = (MAX_SIDE * MAX_SIDE + WORD_W - 1) / WORD_W;
    localparam int AW        = $clog2(MAP_WORDS);
    localparam int WIDX_W    = IDX_W - BIT_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_WORDS - 1);

    logic [WORD_W-1:0] r_map_mem [MAP_WORDS];

    logic              r_clearing;
    logic [AW-1:0]     r_clr_addr;

    logic              r_m1_valid;
    logic              r_m1_clip;
    logic [AW-1:0]     r_m1_addr;
    logic [IDX_W-1:0]  r_m1_idx;
    logic [WORD_W-1:0] r_rdata;

    logic              r_fwd_valid;
    logic [AW-1:0]     r_fwd_addr;
    logic [WORD_W-1:0] r_fwd_word;

    logic [AW+WIDX_W-1:0] req_word_wide;
    logic [AW-1:0]        rd_addr;
    logic [WORD_W-1:0]    cur_word, new_word, wr_data;
    logic [AW-1:0]        wr_addr;
    logic                 bit_set, item_we, wr_en;

    always_comb begin
        req_word_wide = {{AW{1'b0}}, i_req.idx[IDX_W-1:BIT_W]};
        rd_addr       = req_word_wide[AW-1:0];
    end

    always_comb begin
        cur_word = (r_fwd_valid && (r_fwd_addr == r_m1_addr)) ? r_fwd_word : r_rdata;
        bit_set  = cur_word[r_m1_idx[BIT_W-1:0]];
        new_word = cur_word | (WORD_W'(1) << r_m1_idx[BIT_W-1:0]);
        item_we  = r_m1_valid && !r_m1_clip && !bit_set;
        wr_en    = r_clearing || item_we;
        wr_addr  = r_clearing ? r_clr_addr : r_m1_addr;
        wr_data  = r_clearing ? '0 : new_word;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_map_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_map_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_m1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                if (r_clr_addr == LAST_ADDR) begin
                    r_clearing <= 1'b0;
                end else begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                end
            end
            r_m1_valid  <= i_req.valid;
            r_fwd_valid <= item_we;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m1_clip  <= i_req.clip;
        r_m1_addr  <= rd_addr;
        r_m1_idx   <= i_req.idx;
        r_fwd_addr <= r_m1_addr;
        r_fwd_word <= new_word;
    end

    always_comb begin
        o_rsp.valid = r_m1_valid;
        priority if (r_m1_clip) begin
            o_rsp.res.status      = ST_CLIPPED;
            o_rsp.res.pixel_index = '0;
        end else if (bit_set) begin
            o_rsp.res.status      = ST_DUPLICATE;
            o_rsp.res.pixel_index = r_m1_idx[PIX_W-1:0];
        end else begin
            o_rsp.res.status      = ST_PLOTTED;
            o_rsp.res.pixel_index = r_m1_idx[PIX_W-1:0];
        end
    end

    assign o_clearing = r_clearing;

    a_no_req_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid |-> !r_clearing)
        else $error("map request arrived during the clearing pass");

    a_repeat_is_duplicate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m1_valid && !r_m1_clip && $past(r_m1_valid && !r_m1_clip)
         && (r_m1_idx == $past(r_m1_idx)))
        |-> (o_rsp.res.status == ST_DUPLICATE))
        else $error("back-to-back hit on one pixel was not seen as a duplicate");

    a_clear_covers_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clearing) |-> ($past(r_clr_addr) == LAST_ADDR))
        else $error("clearing pass ended before the last map word");

endmodule
`default_nettype wire

// ----- rtl/core/rpor_rfifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Rotated point occupancy raster: result queue
// Small register queue that holds finished results until the output side
// takes them. Space is reserved upstream, so a push never finds it full.
// ----------------------------------------------------------------------------
module rpor_rfifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire rpor_pkg::t_result i_data,
    input  wire logic              i_pop,
    output logic                   o_valid,
    output rpor_pkg::t_result      o_data
);
    import rpor_pkg::*;

    localparam int PTR_W = $clog2(RFIFO_DEPTH);

    t_result          r_slot [RFIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [PTR_W:0]   r_count;
    logic             do_pop;

    assign do_pop  = i_pop && (r_count != '0);
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            unique case ({i_push, do_pop})
                2'b10:   r_count <= r_count + (PTR_W+1)'(1);
                2'b01:   r_count <= r_count - (PTR_W+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/rotated_point_occupancy_raster_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Rotated point occupancy raster core
// Rotates and scales complex points to pixels and marks them in an occupancy
// map, reporting each point as plotted, clipped or duplicate.
// ----------------------------------------------------------------------------
// Usage:
// Points enter on the slave stream: tdata holds point_real (low 32 bits) and
// point_imag (high 32 bits), tuser carries the not-finite flag. Every point
// gives exactly one result on the master stream: tdata holds status in bits
// [1:0] and pixel_index in bits [21:2], bits [23:22] read zero.
// The gains, center and side are set through the APB port while no point is
// in flight; registers sit at byte addresses 0, 4, ... 24.
// A result reaches the master side through the transform stages, map and queue.
// The block takes one point per cycle when the receiver keeps up and no clearing
// pass runs; the map memory has separate read and write ports, and each write is
// forwarded to the following point.
// After reset the map memory is swept to zero, one word a cycle, over all
// (MAX_SIDE*MAX_SIDE+31)/32 words (32768 at the default); tready stays low
// during that time while register writes are taken as usual.
// When the receiver stalls, up to eight results wait in an output queue and
// tready drops once the queue and the pipeline together hold eight points.
// ----------------------------------------------------------------------------
module rotated_point_occupancy_raster_core #(
    parameter int MAX_SIDE = rpor_pkg::MAX_SIDE_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Slave stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [63:0] i_s_axis_tdata,   // point_real[31:0], point_imag[63:32]
    input  wire logic [0:0]  i_s_axis_tuser,   // not_finite[0]
    // Master stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [23:0]      o_m_axis_tdata,   // status[1:0], pixel_index[21:2], zero[23:22]
    // Configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import rpor_pkg::*;

    localparam int USED_W = $clog2(RFIFO_DEPTH + 1);
    localparam logic [USED_W-1:0] USED_MAX = USED_W'(RFIFO_DEPTH);

    t_cfg                  r_cfg;
    logic [USED_W-1:0]     r_used;
    logic [REG_IDX_W-1:0]  reg_idx;
    logic                  cfg_wr, in_acc, out_acc, clearing;
    t_map_req              map_req;
    t_map_rsp              map_rsp;
    t_result               out_res;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.side        <= SIDE_W'(MAX_SIDE_DEF);
            r_cfg.center_real <= '0;
            r_cfg.center_imag <= '0;
            r_cfg.x_from_real <= '0;
            r_cfg.x_from_imag <= '0;
            r_cfg.y_from_real <= '0;
            r_cfg.y_from_imag <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_SIDE:     r_cfg.side        <= pwdata[SIDE_W-1:0];
                REG_CENTER_R: r_cfg.center_real <= pwdata;
                REG_CENTER_I: r_cfg.center_imag <= pwdata;
                REG_X_REAL:   r_cfg.x_from_real <= pwdata;
                REG_X_IMAG:   r_cfg.x_from_imag <= pwdata;
                REG_Y_REAL:   r_cfg.y_from_real <= pwdata;
                REG_Y_IMAG:   r_cfg.y_from_imag <= pwdata;
                default:      r_cfg             <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SIDE:     prdata = {{(DATA_W - SIDE_W){1'b0}}, r_cfg.side};
            REG_CENTER_R: prdata = r_cfg.center_real;
            REG_CENTER_I: prdata = r_cfg.center_imag;
            REG_X_REAL:   prdata = r_cfg.x_from_real;
            REG_X_IMAG:   prdata = r_cfg.x_from_imag;
            REG_Y_REAL:   prdata = r_cfg.y_from_real;
            REG_Y_IMAG:   prdata = r_cfg.y_from_imag;
            default:      prdata = '0;
        endcase
    end

    // Each accepted point holds one queue slot from acceptance until its
    // result is taken, so the queue can never overflow.
    assign o_s_axis_tready = !clearing && (r_used < USED_MAX);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_acc         = o_m_axis_tvalid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            unique case ({in_acc, out_acc})
                2'b10:   r_used <= r_used + USED_W'(1);
                2'b01:   r_used <= r_used - USED_W'(1);
                default: r_used <= r_used;
            endcase
        end
    end

    rpor_xform #(
        .MAX_SIDE (MAX_SIDE)
    ) u_xform (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (in_acc),
        .i_point_real (i_s_axis_tdata[31:0]),
        .i_point_imag (i_s_axis_tdata[63:32]),
        .i_not_finite (i_s_axis_tuser[0]),
        .i_cfg        (r_cfg),
        .o_req        (map_req)
    );

    rpor_map #(
        .MAX_SIDE (MAX_SIDE)
    ) u_map (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (map_req),
        .o_rsp      (map_rsp),
        .o_clearing (clearing)
    );

    rpor_rfifo u_rfifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (map_rsp.valid),
        .i_data  (map_rsp.res),
        .i_pop   (i_m_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_data  (out_res)
    );

    assign o_m_axis_tdata = {2'b00, out_res.pixel_index, out_res.status};

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= USED_MAX)
        else $error("outstanding transaction count exceeds queue depth");

    a_result_has_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        map_rsp.valid |-> (r_used != '0))
        else $error("result produced with no accepted transaction outstanding");

    a_output_has_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_used != '0))
        else $error("output valid with no accepted transaction outstanding");

endmodule
`default_nettype wire
